FILE: hw/rtl/lcdws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdws_pkg
// Types, codes, timing constants and byte tables for the character LCD
// write sequencer.
// ----------------------------------------------------------------------------
package lcdws_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [2:0] KIND_CMD   = 3'd0;
  localparam logic [2:0] KIND_DATA  = 3'd1;
  localparam logic [2:0] KIND_TEXT  = 3'd2;
  localparam logic [2:0] KIND_POS   = 3'd3;
  localparam logic [2:0] KIND_CLEAR = 3'd4;
  localparam logic [2:0] KIND_INIT  = 3'd5;

  localparam logic MODE_BUS8 = 1'b0;
  localparam logic MODE_BUS4 = 1'b1;

  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CMD_HOME  = 8'h80;

  localparam logic [9:0]  PULSE_CMD8   = 10'd1000;
  localparam logic [9:0]  PULSE_SHORT  = 10'd1;
  localparam logic [11:0] WAIT_BUS8    = 12'd3000;
  localparam logic [11:0] WAIT_INIT8   = 12'd4000;
  localparam logic [11:0] WAIT_UPPER   = 12'd200;
  localparam logic [11:0] WAIT_LOWER   = 12'd2000;
  localparam logic [17:0] PRE_INIT8    = 18'd120000;
  localparam logic [17:0] PRE_INIT4    = 18'd150000;
  localparam logic [17:0] PRE_NONE     = 18'd0;

  localparam logic [2:0] INIT_LEN = 3'd6;

  typedef enum logic [1:0] {
    TAIL_NONE  = 2'd0,
    TAIL_HOME  = 2'd1,
    TAIL_CLEAR = 2'd2
  } tail_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] byte_value;
    logic [1:0] row;
    logic [3:0] column;
  } in_item_t;

  typedef struct packed {
    logic        reg_select;
    logic [7:0]  bus_value;
    logic [9:0]  pulse_us;
    logic [11:0] wait_us;
    logic [17:0] pre_wait_us;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic       init;
    logic       rs;
    logic [7:0] main_byte;
    logic [1:0] addr_cnt;
    logic [3:0] addr_nib;
    tail_t      tail;
  } job_t;

  function automatic logic [7:0] init_byte(input logic mode, input logic [2:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (mode == MODE_BUS8) begin
      case (idx)
        3'd0:    b = 8'h38;
        3'd1:    b = 8'h02;
        3'd2:    b = 8'h06;
        3'd3:    b = 8'h80;
        3'd4:    b = 8'h0C;
        default: b = 8'h01;
      endcase
    end else begin
      case (idx)
        3'd0:    b = 8'h33;
        3'd1:    b = 8'h32;
        3'd2:    b = 8'h28;
        3'd3:    b = 8'h0C;
        3'd4:    b = 8'h06;
        default: b = 8'h01;
      endcase
    end
    return b;
  endfunction

  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] b;
    case (row)
      2'd0:    b = 8'h80;
      2'd1:    b = 8'hC0;
      2'd2:    b = 8'h90;
      default: b = 8'hD0;
    endcase
    return b;
  endfunction

endpackage

FILE: hw/rtl/lcdws_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdws_front
// Accepts requests, tracks the text cursor and turns each known request into a
// job descriptor for the transfer sequencer.
// ----------------------------------------------------------------------------
module lcdws_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lcdws_pkg::in_item_t in_data,
  input  logic               q_full,
  output logic               push,
  output lcdws_pkg::job_t    push_job
);

  logic [6:0] cursor_r, cursor_nxt;
  logic       accept;
  logic       known;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && known;

  always_comb begin
    cursor_nxt         = cursor_r;
    known              = 1'b1;
    push_job.init      = 1'b0;
    push_job.rs        = lcdws_pkg::RS_CMD;
    push_job.main_byte = in_data.byte_value;
    push_job.addr_cnt  = 2'd0;
    push_job.addr_nib  = cursor_r[3:0];
    push_job.tail      = lcdws_pkg::TAIL_NONE;
    unique case (in_data.kind)
      lcdws_pkg::KIND_CMD: begin
      end
      lcdws_pkg::KIND_DATA: begin
        push_job.rs = lcdws_pkg::RS_DATA;
      end
      lcdws_pkg::KIND_TEXT: begin
        push_job.rs = lcdws_pkg::RS_DATA;
        if (cursor_r >= 7'd48) begin
          push_job.addr_cnt = 2'd3;
        end else if (cursor_r >= 7'd32) begin
          push_job.addr_cnt = 2'd2;
        end else if (cursor_r >= 7'd16) begin
          push_job.addr_cnt = 2'd1;
        end
        if (cursor_r >= 7'd64) begin
          push_job.tail = lcdws_pkg::TAIL_CLEAR;
          cursor_nxt    = 7'd0;
        end else begin
          cursor_nxt = cursor_r + 7'd1;
        end
      end
      lcdws_pkg::KIND_POS: begin
        push_job.main_byte = lcdws_pkg::row_base(in_data.row) | {4'h0, in_data.column};
        cursor_nxt         = {1'b0, in_data.row, in_data.column};
      end
      lcdws_pkg::KIND_CLEAR: begin
        push_job.main_byte = lcdws_pkg::CMD_CLEAR;
        push_job.tail      = lcdws_pkg::TAIL_HOME;
        cursor_nxt         = 7'd0;
      end
      lcdws_pkg::KIND_INIT: begin
        push_job.init = 1'b1;
        cursor_nxt    = 7'd0;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= 7'd0;
    end else if (accept) begin
      cursor_r <= cursor_nxt;
    end
  end

endmodule

FILE: hw/rtl/lcdws_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdws_queue
// Small first-in first-out buffer of job descriptors between the request
// front end and the transfer sequencer.
// ----------------------------------------------------------------------------
module lcdws_queue #(
  parameter int DEPTH = lcdws_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lcdws_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output lcdws_pkg::job_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  lcdws_pkg::job_t slots_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_pop;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head       = slots_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: hw/rtl/lcdws_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdws_back
// Expands the job at the head of the queue into bus transfers, one per
// cycle while out_stall is low, into a registered output stage.
// ----------------------------------------------------------------------------
module lcdws_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 bus_mode,
  input  logic                 job_valid,
  input  lcdws_pkg::job_t      job,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lcdws_pkg::out_item_t out_data
);

  logic                 out_valid_r;
  lcdws_pkg::out_item_t out_data_r, xfer;
  logic [2:0]           step_r;
  logic                 half_r;
  logic [2:0]           addr_cnt_ext;
  logic [2:0]           n_bytes;
  logic [2:0]           tail_len;
  logic                 last_byte;
  logic                 last_xfer;
  logic [7:0]           cur_byte;
  logic                 cur_rs;
  logic                 advance;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign advance   = job_valid && (!out_valid_r || !out_stall);
  assign pop       = advance && last_xfer;

  always_comb begin
    addr_cnt_ext = {1'b0, job.addr_cnt};
    case (job.tail)
      lcdws_pkg::TAIL_HOME:  tail_len = 3'd1;
      lcdws_pkg::TAIL_CLEAR: tail_len = 3'd2;
      default:               tail_len = 3'd0;
    endcase
    n_bytes   = job.init ? lcdws_pkg::INIT_LEN : addr_cnt_ext + 3'd1 + tail_len;
    last_byte = (step_r == n_bytes - 3'd1);
    last_xfer = last_byte && ((bus_mode == lcdws_pkg::MODE_BUS8) || half_r);

    cur_rs = lcdws_pkg::RS_CMD;
    if (job.init) begin
      cur_byte = lcdws_pkg::init_byte(bus_mode, step_r);
    end else if (step_r < addr_cnt_ext) begin
      cur_byte = lcdws_pkg::row_base(step_r[1:0] + 2'd1) | {4'h0, job.addr_nib};
    end else if (step_r == addr_cnt_ext) begin
      cur_byte = job.main_byte;
      cur_rs   = job.rs;
    end else if ((step_r == addr_cnt_ext + 3'd1) && (job.tail == lcdws_pkg::TAIL_CLEAR)) begin
      cur_byte = lcdws_pkg::CMD_CLEAR;
    end else begin
      cur_byte = lcdws_pkg::CMD_HOME;
    end

    xfer.reg_select  = cur_rs;
    xfer.last        = last_xfer;
    xfer.pre_wait_us = lcdws_pkg::PRE_NONE;
    if (bus_mode == lcdws_pkg::MODE_BUS8) begin
      xfer.bus_value = cur_byte;
      xfer.pulse_us  = cur_rs ? lcdws_pkg::PULSE_SHORT : lcdws_pkg::PULSE_CMD8;
      xfer.wait_us   = (job.init && !last_byte) ? lcdws_pkg::WAIT_INIT8
                                                : lcdws_pkg::WAIT_BUS8;
      if (job.init && (step_r == 3'd0)) begin
        xfer.pre_wait_us = lcdws_pkg::PRE_INIT8;
      end
    end else begin
      xfer.pulse_us = lcdws_pkg::PULSE_SHORT;
      if (!half_r) begin
        xfer.bus_value = {cur_byte[7:4], 4'h0};
        xfer.wait_us   = lcdws_pkg::WAIT_UPPER;
        if (job.init && (step_r == 3'd0)) begin
          xfer.pre_wait_us = lcdws_pkg::PRE_INIT4;
        end
      end else begin
        xfer.bus_value = {cur_byte[3:0], 4'h0};
        xfer.wait_us   = lcdws_pkg::WAIT_LOWER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= 3'd0;
      half_r      <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        if ((bus_mode == lcdws_pkg::MODE_BUS4) && !half_r) begin
          half_r <= 1'b1;
        end else begin
          half_r <= 1'b0;
          step_r <= last_byte ? 3'd0 : step_r + 3'd1;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= xfer;
    end
  end

endmodule

FILE: hw/rtl/char_lcd_write_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer_unit
// Write sequencer for a 16x4 character LCD in eight-bit or four-bit mode.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_stall as in_data transactions: command, raw
// data, text character, set position, clear or init. Each becomes one to
// twelve bus transfers on out_valid/out_stall, one out_data transaction each,
// carrying the register select, the data pins, the enable pulse time and
// the waits; the final transfer of a request has last set. Unknown kinds
// give no transfer. The user writes the bus mode on cfg_we/cfg_wdata only
// while idle; the block does not enforce this. An accepted request passes a
// queue slot and the output register before its first transfer. The sequencer
// emits one transfer per cycle unless out_stall holds it; a queue of job
// descriptors lets the front end accept further requests meanwhile and raises
// in_stall only when it is full. When out_stall is high the current transfer
// holds and the sequencer waits. Synchronous reset clears the cursor, the
// queue, the output stage and sets eight-bit mode.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer_unit #(
  parameter int QUEUE_DEPTH = lcdws_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lcdws_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lcdws_pkg::out_item_t out_data
);

  logic            bus_mode_r;
  logic            q_full;
  logic            push;
  lcdws_pkg::job_t push_job;
  logic            pop;
  logic            head_valid;
  lcdws_pkg::job_t head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_mode_r <= lcdws_pkg::MODE_BUS8;
    end else if (cfg_we) begin
      bus_mode_r <= cfg_wdata;
    end
  end

  lcdws_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  lcdws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  lcdws_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .bus_mode  (bus_mode_r),
    .job_valid (head_valid),
    .job       (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: hw/rtl/lcdws_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdws_checker
// Port-level checks on the transfer channel of the LCD write sequencer.
// ----------------------------------------------------------------------------
module lcdws_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input lcdws_pkg::out_item_t out_data
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled transaction changed or dropped.");

  a_data_short_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reg_select |-> out_data.pulse_us == 10'd1)
    else $error("Data transfer with a long enable pulse.");

  a_pre_wait_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.pre_wait_us != 18'd0) |->
      !out_data.reg_select && !out_data.last)
    else $error("Power-on wait on a transfer that is not the first of an init.");

  a_pulse_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.pulse_us != 10'd0)
    else $error("Enable pulse of zero length.");

endmodule

bind char_lcd_write_sequencer_unit lcdws_checker u_lcdws_checker (.*);

FILE: sim/char_lcd_write_sequencer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer_unit_test
// Self-checking testbench for the character LCD write sequencer.
// ----------------------------------------------------------------------------
// Requests are driven on the input channel with random gaps and bus transfers
// are taken from the output channel with random stalls. A scoreboard keeps
// its own copy of the bus mode, cursor pointer and row, works out the list of
// transfers each accepted request must cause and compares every transfer
// field by field in order. A directed pass covers field extremes, every
// request kind, the row crossings of the text cursor, the end-of-screen clear
// in both bus modes, and the ignored kinds in 8-bit mode. Random phases then
// alternate the bus mode, mixing text runs from random positions with other
// requests, a long output hold-off and pauses until the sequencer is empty.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer_unit_test;

  localparam int CLK_HALF         = 5;
  localparam int RESET_CYCLES     = 12;
  localparam int MAX_GAP          = 13;
  localparam int SETTLE_CYCLES    = 24;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PHASE_REQUESTS   = 35;
  localparam int CYCLE_LIMIT      = 500000;

  localparam logic [2:0] KIND_UNUSED_6 = 3'd6;
  localparam logic [2:0] KIND_UNUSED_7 = 3'd7;

  class lcd_transfer_scoreboard;
    localparam logic [11:0] INIT8_EXTRA_WAIT = 12'd1000;
    localparam logic [47:0] INIT_SEQ_BUS8    = 48'h38_02_06_80_0C_01;
    localparam logic [47:0] INIT_SEQ_BUS4    = 48'h33_32_28_0C_06_01;
    localparam logic [31:0] ROW_BASES        = 32'hD0_90_C0_80;

    logic                 bus_mode;
    logic [6:0]           cursor_pos;
    logic [1:0]           cursor_row;
    lcdws_pkg::out_item_t transfers_due[$];
    lcdws_pkg::out_item_t request_burst[$];
    int                   mismatches;

    function new();
      bus_mode   = lcdws_pkg::MODE_BUS8;
      cursor_pos = '0;
      cursor_row = '0;
      mismatches = 0;
    endfunction

    function void put_byte(input logic rs, input logic [7:0] b,
                           input logic [11:0] extra_wait, input logic [17:0] pre_wait);
      lcdws_pkg::out_item_t t;
      t = '0;
      t.reg_select  = rs;
      t.pre_wait_us = pre_wait;
      if (bus_mode == lcdws_pkg::MODE_BUS8) begin
        t.bus_value = b;
        t.pulse_us  = (rs == lcdws_pkg::RS_DATA) ? lcdws_pkg::PULSE_SHORT
                                                 : lcdws_pkg::PULSE_CMD8;
        t.wait_us   = lcdws_pkg::WAIT_BUS8 + extra_wait;
        request_burst.push_back(t);
      end else begin
        t.bus_value = {b[7:4], 4'h0};
        t.pulse_us  = lcdws_pkg::PULSE_SHORT;
        t.wait_us   = lcdws_pkg::WAIT_UPPER;
        request_burst.push_back(t);
        t.bus_value   = {b[3:0], 4'h0};
        t.wait_us     = lcdws_pkg::WAIT_LOWER + extra_wait;
        t.pre_wait_us = lcdws_pkg::PRE_NONE;
        request_burst.push_back(t);
      end
    endfunction

    function void clear_display();
      cursor_pos = '0;
      cursor_row = '0;
      put_byte(lcdws_pkg::RS_CMD, lcdws_pkg::CMD_CLEAR, 12'd0, lcdws_pkg::PRE_NONE);
      put_byte(lcdws_pkg::RS_CMD, lcdws_pkg::CMD_HOME, 12'd0, lcdws_pkg::PRE_NONE);
    endfunction

    function void note_request(input lcdws_pkg::in_item_t req);
      logic [6:0] p;
      request_burst.delete();
      case (req.kind)
        lcdws_pkg::KIND_CMD:
          put_byte(lcdws_pkg::RS_CMD, req.byte_value, 12'd0, lcdws_pkg::PRE_NONE);
        lcdws_pkg::KIND_DATA:
          put_byte(lcdws_pkg::RS_DATA, req.byte_value, 12'd0, lcdws_pkg::PRE_NONE);
        lcdws_pkg::KIND_TEXT: begin
          p = cursor_pos;
          if (p >= 7'd16) begin
            put_byte(lcdws_pkg::RS_CMD, {4'hC, p[3:0]}, 12'd0, lcdws_pkg::PRE_NONE);
            cursor_row = 2'd1;
          end
          if (p >= 7'd32) begin
            put_byte(lcdws_pkg::RS_CMD, {4'h9, p[3:0]}, 12'd0, lcdws_pkg::PRE_NONE);
            cursor_row = 2'd2;
          end
          if (p >= 7'd48) begin
            put_byte(lcdws_pkg::RS_CMD, {4'hD, p[3:0]}, 12'd0, lcdws_pkg::PRE_NONE);
            cursor_row = 2'd3;
          end
          put_byte(lcdws_pkg::RS_DATA, req.byte_value, 12'd0, lcdws_pkg::PRE_NONE);
          if (p >= 7'd64) begin
            clear_display();
          end else begin
            cursor_pos = p + 7'd1;
          end
        end
        lcdws_pkg::KIND_POS: begin
          put_byte(lcdws_pkg::RS_CMD, ROW_BASES[8*req.row +: 8] | {4'h0, req.column},
                   12'd0, lcdws_pkg::PRE_NONE);
          cursor_pos = {1'b0, req.row, req.column};
          cursor_row = req.row;
        end
        lcdws_pkg::KIND_CLEAR: clear_display();
        lcdws_pkg::KIND_INIT: begin
          cursor_pos = '0;
          cursor_row = '0;
          for (int i = 0; i < 6; i++) begin
            if (bus_mode == lcdws_pkg::MODE_BUS8) begin
              put_byte(lcdws_pkg::RS_CMD, INIT_SEQ_BUS8[47 - 8*i -: 8],
                       (i < 5) ? INIT8_EXTRA_WAIT : 12'd0,
                       (i == 0) ? lcdws_pkg::PRE_INIT8 : lcdws_pkg::PRE_NONE);
            end else begin
              put_byte(lcdws_pkg::RS_CMD, INIT_SEQ_BUS4[47 - 8*i -: 8], 12'd0,
                       (i == 0) ? lcdws_pkg::PRE_INIT4 : lcdws_pkg::PRE_NONE);
            end
          end
        end
        default: ;
      endcase
      if (request_burst.size() > 0) begin
        request_burst[request_burst.size() - 1].last = 1'b1;
      end
      foreach (request_burst[k]) begin
        transfers_due.push_back(request_burst[k]);
      end
    endfunction

    task report_mismatch(input string what, input int got, input int want);
      if (mismatches < 50) begin
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      end
      mismatches++;
    endtask

    task check_transfer(input lcdws_pkg::out_item_t got);
      lcdws_pkg::out_item_t want;
      if (transfers_due.size() == 0) begin
        report_mismatch("transfer with none outstanding, bus_value",
                        int'(got.bus_value), -1);
        return;
      end
      want = transfers_due.pop_front();
      if (got.reg_select != want.reg_select)
        report_mismatch("reg_select", int'(got.reg_select), int'(want.reg_select));
      if (got.bus_value != want.bus_value)
        report_mismatch("bus_value", int'(got.bus_value), int'(want.bus_value));
      if (got.pulse_us != want.pulse_us)
        report_mismatch("pulse_us", int'(got.pulse_us), int'(want.pulse_us));
      if (got.wait_us != want.wait_us)
        report_mismatch("wait_us", int'(got.wait_us), int'(want.wait_us));
      if (got.pre_wait_us != want.pre_wait_us)
        report_mismatch("pre_wait_us", int'(got.pre_wait_us), int'(want.pre_wait_us));
      if (got.last != want.last)
        report_mismatch("last", int'(got.last), int'(want.last));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic                 cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  lcdws_pkg::in_item_t  in_data;
  logic                 out_valid;
  logic                 out_stall;
  lcdws_pkg::out_item_t out_data;

  lcd_transfer_scoreboard sb;
  int  requests_sent;
  int  rx_wait;
  int  cycle_count;
  bit  tx_idle_en;
  bit  rx_idle_en;
  bit  rx_hold_on;
  event hold_start;

  char_lcd_write_sequencer_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #(CLK_HALF) clk = ~clk;

  always @(negedge clk) begin
    out_stall <= rx_hold_on || (rx_wait != 0);
    if (rx_wait != 0) begin
      rx_wait = rx_wait - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_transfer(out_data);
        rx_wait = rx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (in_valid && !in_stall) begin
        sb.note_request(in_data);
      end
    end
  end

  initial begin
    rx_hold_on = 1'b0;
    forever begin
      @(hold_start);
      rx_hold_on = 1'b1;
      repeat (LONG_HOLD_CYCLES) @(negedge clk);
      rx_hold_on = 1'b0;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  task automatic send_request(input logic [2:0] k, input logic [7:0] b,
                              input logic [1:0] r, input logic [3:0] c);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= '{kind: k, byte_value: b, row: r, column: c};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (k <= lcdws_pkg::KIND_INIT) begin
      requests_sent++;
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.transfers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_bus_mode(input logic m);
    cfg_wdata <= m;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we      <= 1'b0;
    sb.bus_mode = m;
  endtask

  task automatic send_random_request();
    int pick;
    logic [2:0] k;
    pick = $urandom_range(0, 99);
    if (pick < 40)      k = lcdws_pkg::KIND_TEXT;
    else if (pick < 52) k = lcdws_pkg::KIND_CMD;
    else if (pick < 64) k = lcdws_pkg::KIND_DATA;
    else if (pick < 78) k = lcdws_pkg::KIND_POS;
    else if (pick < 84) k = lcdws_pkg::KIND_CLEAR;
    else if (pick < 90) k = lcdws_pkg::KIND_INIT;
    else                k = ($urandom_range(0, 1) != 0) ? KIND_UNUSED_6 : KIND_UNUSED_7;
    send_request(k, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                 4'($urandom_range(0, 15)));
  endtask

  task automatic run_random_phase(input int goal, input bit with_hold);
    int target;
    int run_len;
    bit hold_done;
    target    = requests_sent + goal;
    hold_done = 1'b0;
    while (requests_sent < target) begin
      if (with_hold && !hold_done && requests_sent >= target - goal + 4) begin
        tx_idle_en = 1'b1;
        -> hold_start;
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_request(lcdws_pkg::KIND_POS, 8'($urandom_range(0, 255)),
                     2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
        run_len = $urandom_range(4, 20);
        repeat (run_len) begin
          send_request(lcdws_pkg::KIND_TEXT, 8'($urandom_range(0, 255)),
                       2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
        end
      end else begin
        send_random_request();
      end
      if ($urandom_range(0, 29) == 0) begin
        tx_idle_en = ($urandom_range(0, 2) != 0);
        rx_idle_en = ($urandom_range(0, 2) != 0);
      end
    end
  endtask

  initial begin
    sb            = new();
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    rx_wait       = 0;
    requests_sent = 0;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_bus_mode(lcdws_pkg::MODE_BUS8);
    send_request(lcdws_pkg::KIND_INIT, 8'h00, 2'd0, 4'd0);
    send_request(lcdws_pkg::KIND_CMD, 8'h00, 2'd3, 4'd15);
    send_request(lcdws_pkg::KIND_CMD, 8'hFF, 2'd0, 4'd0);
    send_request(lcdws_pkg::KIND_DATA, 8'hFF, 2'd3, 4'd15);
    send_request(lcdws_pkg::KIND_DATA, 8'h00, 2'd0, 4'd0);
    send_request(lcdws_pkg::KIND_POS, 8'h00, 2'd3, 4'd15);
    send_request(lcdws_pkg::KIND_TEXT, 8'hA5, 2'd0, 4'd0);
    send_request(lcdws_pkg::KIND_TEXT, 8'h5A, 2'd0, 4'd0);
    send_request(lcdws_pkg::KIND_POS, 8'hFF, 2'd1, 4'd0);
    send_request(lcdws_pkg::KIND_TEXT, 8'h41, 2'd0, 4'd0);
    send_request(lcdws_pkg::KIND_POS, 8'h00, 2'd2, 4'd0);
    send_request(lcdws_pkg::KIND_TEXT, 8'h7E, 2'd0, 4'd0);
    send_request(lcdws_pkg::KIND_CLEAR, 8'hFF, 2'd3, 4'd15);
    send_request(KIND_UNUSED_6, 8'hFF, 2'd3, 4'd15);
    send_request(KIND_UNUSED_7, 8'h00, 2'd0, 4'd0);
    wait_idle();

    write_bus_mode(lcdws_pkg::MODE_BUS4);
    send_request(lcdws_pkg::KIND_INIT, 8'hFF, 2'd3, 4'd15);
    send_request(lcdws_pkg::KIND_CMD, 8'hFF, 2'd0, 4'd0);
    send_request(lcdws_pkg::KIND_DATA, 8'h0F, 2'd0, 4'd0);
    send_request(lcdws_pkg::KIND_POS, 8'h00, 2'd0, 4'd0);
    send_request(lcdws_pkg::KIND_POS, 8'h00, 2'd3, 4'd15);
    send_request(lcdws_pkg::KIND_TEXT, 8'hF0, 2'd0, 4'd0);
    send_request(lcdws_pkg::KIND_TEXT, 8'h3C, 2'd0, 4'd0);
    send_request(lcdws_pkg::KIND_CLEAR, 8'h00, 2'd0, 4'd0);

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      write_bus_mode((ph % 2 == 0) ? lcdws_pkg::MODE_BUS8 : lcdws_pkg::MODE_BUS4);
      run_random_phase(PHASE_REQUESTS, ph == 1 || ph == 4);
    end
    wait_idle();

    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
